/* hdl/sample_statistics_engine_macros.svh */
// ----------------------------------------------------------------------------
// Sample statistics engine assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_STATISTICS_ENGINE_MACROS_SVH
`define SAMPLE_STATISTICS_ENGINE_MACROS_SVH

// same-cycle implication
`define SSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sample statistics check failed");

// next-cycle implication
`define SSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sample statistics check failed");

`endif

/* hdl/sse_pkg.sv */
// ----------------------------------------------------------------------------
// Sample statistics engine package
// Shared widths, register indexes, controller states, opcodes and structs.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int unsigned SSE_CAPACITY = 1024;
  localparam int unsigned SSE_SAMPLE_W = 32;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned SPREAD_W    = 63;
  localparam int unsigned RATIO_W     = 7;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_FIELD_W = COUNT_W + 4 * VALUE_W + SPREAD_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANK  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTS = 1'd1;

  localparam logic [RATIO_W-1:0] RANK_RST  = 7'd1;
  localparam logic [RATIO_W-1:0] PARTS_RST = 7'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQUARE, ST_ACC, ST_INSERT,
    ST_RD_MIN, ST_RD_MAX, ST_GET_MAX,
    ST_MEAN_GO, ST_MEAN_WAIT, ST_QUANT_GO, ST_QUANT_WAIT,
    ST_RD_QA, ST_RD_QB, ST_GET_Q,
    ST_SCALE_GO, ST_SCALE_WAIT, ST_SQ_GO, ST_SQ_WAIT,
    ST_SPREAD_GO, ST_SPREAD_WAIT, ST_EMIT
  } sse_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SQUARE, OP_ACC, OP_INSERT,
    OP_RD_MIN, OP_RD_MAX, OP_GET_MAX,
    OP_MEAN_GO, OP_MEAN_WAIT, OP_QUANT_GO, OP_QUANT_WAIT,
    OP_RD_QA, OP_RD_QB, OP_GET_Q,
    OP_SCALE_GO, OP_SCALE_WAIT, OP_SQ_GO, OP_SQ_WAIT,
    OP_SPREAD_GO, OP_SPREAD_WAIT, OP_EMIT
  } sse_op_e;

  typedef struct packed {
    sse_op_e op;
    logic    s_ready;
  } sse_cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic ins_done;
    logic div_done;
    logic mul_done;
    logic n_ge2;
    logic out_free;
  } sse_status_t;

endpackage

/* hdl/sse_divider.sv */
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned quotient and remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sse_divider #(
  parameter int unsigned N_W = 16,
  parameter int unsigned D_W = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  output logic [N_W-1:0] quo_o,
  output logic [D_W-1:0] rem_o,
  output logic           done_o
);

  localparam int unsigned CNT_W = $clog2(N_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic [N_W-1:0]   quo_q;
  logic [D_W-1:0]   rem_q, den_q;
  logic [D_W:0]     trial;
  logic             fits;

  // shift in next dividend bit, subtract when it fits
  assign trial = {rem_q, quo_q[N_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(N_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[N_W-2:0], fits};
      rem_q <= fits ? D_W'(trial - {1'b0, den_q}) : trial[D_W-1:0];
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = (cnt_q == '0);

endmodule

/* hdl/sse_datapath.sv */
// ----------------------------------------------------------------------------
// Sample statistics datapath
// Sorted sample memory, accumulators, shift-add multiplier, shared divider
// and the result register, all stepped by controller opcodes.
// ----------------------------------------------------------------------------
module sse_datapath import sse_pkg::*; #(
  parameter int unsigned SAMPLE_CAPACITY = SSE_CAPACITY,
  parameter int unsigned SAMPLE_WIDTH    = SSE_SAMPLE_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   s_tlast_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [RATIO_W-1:0]     cfg_data_i,
  input  sse_cmd_t               cmd_i,
  output sse_status_t            status_o,
  input  logic                   m_tready_i,
  output logic                   m_tvalid_o,
  output logic [OUT_TDATA_W-1:0] m_tdata_o,
  output logic [OUT_TUSER_W-1:0] m_tuser_o
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned CNT_W = $clog2(SAMPLE_CAPACITY + 1);
  localparam int unsigned AW    = $clog2(SAMPLE_CAPACITY);
  localparam int unsigned SUM_W = SW + CNT_W;
  localparam int unsigned S2_W  = 2 * SW + CNT_W;
  localparam int unsigned NUM_W = 2 * SW + 2 * CNT_W;
  localparam int unsigned DEN_W = 2 * CNT_W + 16;
  localparam int unsigned MC_W  = $clog2(SUM_W + 1);
  localparam int unsigned QP_W  = RATIO_W + CNT_W + 1;
  localparam int unsigned PAD_W = OUT_TDATA_W - OUT_FIELD_W;

  sse_op_e op;
  assign op = cmd_i.op;

  // batch state
  logic signed [SW-1:0]    sample_q;
  logic                    last_q;
  logic [CNT_W-1:0]        count_q, pos_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [S2_W-1:0]         s2_q;
  logic [2*SW-1:0]         sq_q;
  logic                    ovf_q;
  logic [RATIO_W-1:0]      rank_q, parts_q;

  // sample memory
  logic signed [SW-1:0] mem [SAMPLE_CAPACITY];
  logic signed [SW-1:0] rdata_q, wdata;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 we;

  // multiplier and divider
  logic [NUM_W-1:0] mul_a_q, mul_acc_q;
  logic [SUM_W-1:0] mul_b_q;
  logic [MC_W-1:0]  mul_cnt_q;
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den, div_rem;

  // results
  logic signed [SW-1:0] min_q, max_q, mean_q, quant_q, qa_val_q;
  logic [AW-1:0]        qa_addr_q, qb_addr_q;
  logic                 use_mid_q;
  logic [NUM_W-1:0]     scaled_q, numer_q;
  logic [SPREAD_W-1:0]  spread_q;

  // result register
  logic                m_valid_q;
  logic [COUNT_W-1:0]  o_count_q;
  logic [VALUE_W-1:0]  o_min_q, o_max_q, o_mean_q, o_quant_q;
  logic [SPREAD_W-1:0] o_spread_q;
  logic                o_spread_valid_q, o_dropped_q;

  // derived values
  logic signed [SW-1:0]  new_sample;
  logic [SW-1:0]         samp_mag;
  logic [SUM_W-1:0]      sum_mag;
  logic [CNT_W-1:0]      n_m1;
  logic [QP_W-1:0]       qprod;
  logic [RATIO_W-1:0]    parts_eff;
  logic [2*CNT_W-1:0]    nn1;
  logic [NUM_W-1:0]      mean_val, q_m1;
  logic                  q_lo, q_hi, ins_done, out_free;
  logic signed [SW:0]    msum, mrnd;
  logic [NUM_W+62:0]     quo_ext;

  assign new_sample = s_tdata_i[SW-1:0];
  assign samp_mag   = sample_q[SW-1] ? SW'(-sample_q) : SW'(sample_q);
  assign sum_mag    = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign n_m1       = count_q - 1'b1;
  assign qprod      = QP_W'(rank_q) * (QP_W'(count_q) + QP_W'(1));
  assign parts_eff  = (parts_q == '0) ? RATIO_W'(1) : parts_q;
  assign nn1        = (2*CNT_W)'(count_q) * (2*CNT_W)'(n_m1);
  assign mean_val   = sum_q[SUM_W-1] ? NUM_W'(-div_quo) : div_quo;
  assign q_m1       = div_quo - 1'b1;
  assign q_lo       = (div_quo == '0);
  assign q_hi       = (div_quo >= NUM_W'(count_q));
  assign quo_ext    = (NUM_W+63)'(div_quo);
  assign ins_done   = (pos_q == '0) || !(rdata_q > sample_q);
  assign out_free   = !m_valid_q || m_tready_i;

  // midpoint truncated toward zero
  assign msum = (SW+1)'(qa_val_q) + (SW+1)'(rdata_q);
  assign mrnd = msum + $signed({{SW{1'b0}}, msum[SW]});

  // memory address and write selection
  always_comb begin
    case (op)
      OP_ACC:    rd_addr = AW'(n_m1);
      OP_INSERT: rd_addr = AW'(pos_q - CNT_W'(2));
      OP_RD_MAX: rd_addr = AW'(n_m1);
      OP_RD_QA:  rd_addr = qa_addr_q;
      OP_RD_QB:  rd_addr = qb_addr_q;
      default:   rd_addr = '0;
    endcase
  end

  assign we      = (op == OP_INSERT);
  assign wr_addr = AW'(pos_q);
  assign wdata   = ins_done ? sample_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  // divider operand selection
  always_comb begin
    div_start = 1'b1;
    case (op)
      OP_MEAN_GO: begin
        div_num = NUM_W'(sum_mag);
        div_den = DEN_W'(count_q);
      end
      OP_QUANT_GO: begin
        div_num = NUM_W'(qprod);
        div_den = DEN_W'(parts_eff);
      end
      OP_SPREAD_GO: begin
        div_num = numer_q;
        div_den = {nn1, 16'd0};
      end
      default: begin
        div_start = 1'b0;
        div_num   = numer_q;
        div_den   = {nn1, 16'd0};
      end
    endcase
  end

  sse_divider #(
    .N_W (NUM_W),
    .D_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .rem_o   (div_rem),
    .done_o  (div_done)
  );

  // batch control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      s2_q    <= '0;
      ovf_q   <= 1'b0;
    end else begin
      case (op)
        OP_LOAD: begin
          if (count_q == CNT_W'(SAMPLE_CAPACITY)) ovf_q <= 1'b1;
        end
        OP_SQUARE: sum_q <= sum_q + SUM_W'(sample_q);
        OP_ACC:    s2_q  <= s2_q + S2_W'(sq_q);
        OP_INSERT: begin
          if (ins_done) count_q <= count_q + 1'b1;
        end
        OP_EMIT: begin
          count_q <= '0;
          sum_q   <= '0;
          s2_q    <= '0;
          ovf_q   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q  <= RANK_RST;
      parts_q <= PARTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_RANK:  rank_q  <= cfg_data_i;
        REG_PARTS: parts_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shift-add multiplier, one multiplier bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_cnt_q <= '0;
    end else if (op == OP_SCALE_GO || op == OP_SQ_GO) begin
      mul_cnt_q <= MC_W'(SUM_W);
    end else if (mul_cnt_q != '0) begin
      mul_cnt_q <= mul_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_SCALE_GO) begin
      mul_a_q   <= NUM_W'(s2_q);
      mul_b_q   <= SUM_W'(count_q);
      mul_acc_q <= '0;
    end else if (op == OP_SQ_GO) begin
      mul_a_q   <= NUM_W'(sum_mag);
      mul_b_q   <= sum_mag;
      mul_acc_q <= '0;
    end else if (mul_cnt_q != '0) begin
      if (mul_b_q[0]) mul_acc_q <= mul_acc_q + mul_a_q;
      mul_a_q <= mul_a_q << 1;
      mul_b_q <= mul_b_q >> 1;
    end
  end

  // payload steps
  always_ff @(posedge clk_i) begin
    case (op)
      OP_LOAD: begin
        sample_q <= new_sample;
        last_q   <= s_tlast_i;
      end
      OP_SQUARE:  sq_q  <= samp_mag * samp_mag;
      OP_ACC:     pos_q <= count_q;
      OP_INSERT: begin
        if (!ins_done) pos_q <= pos_q - 1'b1;
      end
      OP_RD_MAX:    min_q  <= rdata_q;
      OP_GET_MAX:   max_q  <= rdata_q;
      OP_MEAN_WAIT: mean_q <= mean_val[SW-1:0];
      OP_QUANT_WAIT: begin
        qa_addr_q <= q_lo ? '0 : (q_hi ? AW'(n_m1) : AW'(q_m1));
        qb_addr_q <= AW'(div_quo);
        use_mid_q <= !q_lo && !q_hi && (div_rem != '0);
      end
      OP_RD_QB:       qa_val_q <= rdata_q;
      OP_GET_Q:       quant_q  <= use_mid_q ? mrnd[SW:1] : qa_val_q;
      OP_SCALE_WAIT:  scaled_q <= mul_acc_q;
      OP_SQ_WAIT:     numer_q  <= scaled_q - mul_acc_q;
      OP_SPREAD_WAIT: begin
        spread_q <= (|quo_ext[NUM_W+62:63]) ? '1 : quo_ext[62:0];
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (op == OP_EMIT) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_EMIT) begin
      o_count_q        <= COUNT_W'(count_q);
      o_min_q          <= VALUE_W'(min_q);
      o_max_q          <= VALUE_W'(max_q);
      o_mean_q         <= VALUE_W'(mean_q);
      o_quant_q        <= VALUE_W'(quant_q);
      o_spread_q       <= (count_q >= CNT_W'(2)) ? spread_q : '0;
      o_spread_valid_q <= (count_q >= CNT_W'(2));
      o_dropped_q      <= ovf_q;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {PAD_W'(0), o_quant_q, o_spread_q, o_mean_q, o_max_q, o_min_q,
                       o_count_q};
  assign m_tuser_o  = {o_dropped_q, o_spread_valid_q};

  assign status_o.full     = (count_q == CNT_W'(SAMPLE_CAPACITY));
  assign status_o.last     = last_q;
  assign status_o.ins_done = ins_done;
  assign status_o.div_done = div_done;
  assign status_o.mul_done = (mul_cnt_q == '0);
  assign status_o.n_ge2    = (count_q >= CNT_W'(2));
  assign status_o.out_free = out_free;

endmodule

/* hdl/sse_ctrl.sv */
// ----------------------------------------------------------------------------
// Sample statistics controller
// Sequences sample insertion and the end-of-batch statistics pass.
// ----------------------------------------------------------------------------
module sse_ctrl import sse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tlast_i,
  input  sse_status_t status_i,
  output sse_cmd_t    cmd_o
);

  sse_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and opcode
  always_comb begin
    state_d       = state_q;
    cmd_o.op      = OP_NONE;
    cmd_o.s_ready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.s_ready = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.op = OP_LOAD;
          if (!status_i.full) state_d = ST_SQUARE;
          else if (s_tlast_i) state_d = ST_RD_MIN;
        end
      end
      ST_SQUARE: begin
        cmd_o.op = OP_SQUARE;
        state_d  = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.op = OP_ACC;
        state_d  = ST_INSERT;
      end
      ST_INSERT: begin
        cmd_o.op = OP_INSERT;
        if (status_i.ins_done) state_d = status_i.last ? ST_RD_MIN : ST_IDLE;
      end
      ST_RD_MIN: begin
        cmd_o.op = OP_RD_MIN;
        state_d  = ST_RD_MAX;
      end
      ST_RD_MAX: begin
        cmd_o.op = OP_RD_MAX;
        state_d  = ST_GET_MAX;
      end
      ST_GET_MAX: begin
        cmd_o.op = OP_GET_MAX;
        state_d  = ST_MEAN_GO;
      end
      ST_MEAN_GO: begin
        cmd_o.op = OP_MEAN_GO;
        state_d  = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        cmd_o.op = OP_MEAN_WAIT;
        if (status_i.div_done) state_d = ST_QUANT_GO;
      end
      ST_QUANT_GO: begin
        cmd_o.op = OP_QUANT_GO;
        state_d  = ST_QUANT_WAIT;
      end
      ST_QUANT_WAIT: begin
        cmd_o.op = OP_QUANT_WAIT;
        if (status_i.div_done) state_d = ST_RD_QA;
      end
      ST_RD_QA: begin
        cmd_o.op = OP_RD_QA;
        state_d  = ST_RD_QB;
      end
      ST_RD_QB: begin
        cmd_o.op = OP_RD_QB;
        state_d  = ST_GET_Q;
      end
      ST_GET_Q: begin
        cmd_o.op = OP_GET_Q;
        state_d  = status_i.n_ge2 ? ST_SCALE_GO : ST_EMIT;
      end
      ST_SCALE_GO: begin
        cmd_o.op = OP_SCALE_GO;
        state_d  = ST_SCALE_WAIT;
      end
      ST_SCALE_WAIT: begin
        cmd_o.op = OP_SCALE_WAIT;
        if (status_i.mul_done) state_d = ST_SQ_GO;
      end
      ST_SQ_GO: begin
        cmd_o.op = OP_SQ_GO;
        state_d  = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        cmd_o.op = OP_SQ_WAIT;
        if (status_i.mul_done) state_d = ST_SPREAD_GO;
      end
      ST_SPREAD_GO: begin
        cmd_o.op = OP_SPREAD_GO;
        state_d  = ST_SPREAD_WAIT;
      end
      ST_SPREAD_WAIT: begin
        cmd_o.op = OP_SPREAD_WAIT;
        if (status_i.div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the result register can take the item
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* hdl/sample_statistics_engine.sv */
// ----------------------------------------------------------------------------
// Sample statistics engine
// Keeps a batch of Q16.16 samples sorted and reports count, min, max, mean,
// sample variance and one quantile when the last sample arrives.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake             Payload
//   s_axis    in         tvalid / tready       sample_value, last_sample
//   m_axis    out        tvalid / tready       statistics result, flags
//   cfg       in         cfg_valid / ready     quantile_rank, quantile_parts
//
// When the store is full a sample is only taken in and dropped; otherwise it is
// loaded, squared and accumulated, then inserted by shifting each stored sample
// larger than it up one place (insertion shifts through one memory port).
// The final pass runs the serial divider for mean and quantile and, when two or
// more samples are kept, the serial multiplier and divider for the spread.
// Reset clears the counters; the sample memory needs no clearing.
// A stalled result waits in the output register while the next batch loads.
// ----------------------------------------------------------------------------
module sample_statistics_engine import sse_pkg::*; #(
  parameter int unsigned SAMPLE_CAPACITY = SSE_CAPACITY,
  parameter int unsigned SAMPLE_WIDTH    = SSE_SAMPLE_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // sample_value [31:0]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   s_axis_tlast_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // sample_count [10:0], minimum [42:11], maximum [74:43], mean [106:75],
  // spread [169:107], quantile_value [201:170], zero fill above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // spread_valid [0], dropped [1]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [RATIO_W-1:0]     cfg_data_i
);

  sse_cmd_t    cmd;
  sse_status_t status;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = cmd.s_ready;

  sse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tlast_i  (s_axis_tlast_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sse_datapath #(
    .SAMPLE_CAPACITY (SAMPLE_CAPACITY),
    .SAMPLE_WIDTH    (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tlast_i   (s_axis_tlast_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_tready_i  (m_axis_tready_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tuser_o   (m_axis_tuser_o)
  );

endmodule

/* hdl/sse_checker.sv */
// ----------------------------------------------------------------------------
// Sample statistics port checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "sample_statistics_engine_macros.svh"

module sse_checker import sse_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tlast_i,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i
);

  logic [COUNT_W-1:0] out_count;
  assign out_count = m_axis_tdata_o[COUNT_W-1:0];

  // a stalled result stays offered
  `SSE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)
  // every result holds at least one sample
  `SSE_ASSERT_NOW(a_count_nonzero, clk_i, rst_ni, m_axis_tvalid_o, out_count != '0)
  // variance only flagged with two or more samples
  `SSE_ASSERT_NOW(a_spread_flag, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0], out_count >= COUNT_W'(2))
  // closing a batch starts the statistics pass
  `SSE_ASSERT_NEXT(a_last_busy, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, !s_axis_tready_o)

endmodule

bind sample_statistics_engine sse_checker u_sse_checker (.*);
